// ===== design/hti_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Humidity table interpolator package
// Resistance table, row bounds, widths and shared types for the humidity
// table interpolator pipeline.
// ----------------------------------------------------------------------------
package hti_pkg;

  localparam int ROWS      = 13;
  localparam int COLS      = 15;
  localparam int RES_W     = 24;
  localparam int TEMP_W    = 12;
  localparam int HUM_W     = 7;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 4;
  localparam int SCALED_W  = 28;
  localparam int QUO_W     = 5;
  localparam int TEMP_STEP = 25;
  localparam int HUM_MIN   = 10;
  localparam int HUM_MAX   = 99;
  localparam int HUM_STEP  = 5;
  localparam int COL_OFS   = 4;

  typedef logic [RES_W-1:0] res_t;

  typedef struct packed {
    logic [HUM_W-1:0] base;
    logic             sub;
  } hti_ctl_t;

  localparam res_t RTAB [ROWS][COLS] = '{
    '{24'd0, 24'd0, 24'd6400000, 24'd2900000, 24'd1400000, 24'd700000, 24'd370000,
      24'd190000, 24'd105000, 24'd62000, 24'd38000, 24'd23000, 24'd15500, 24'd10500,
      24'd7100},
    '{24'd0, 24'd10000000, 24'd4600000, 24'd2100000, 24'd1000000, 24'd500000,
      24'd260000, 24'd140000, 24'd80000, 24'd48000, 24'd30000, 24'd18000, 24'd12000,
      24'd8200, 24'd5300},
    '{24'd0, 24'd7000000, 24'd3200000, 24'd1500000, 24'd750000, 24'd380000,
      24'd200000, 24'd110000, 24'd62000, 24'd37000, 24'd24000, 24'd15000, 24'd10000,
      24'd6800, 24'd4700},
    '{24'd10000000, 24'd5000000, 24'd2300000, 24'd1100000, 24'd540000, 24'd280000,
      24'd150000, 24'd84000, 24'd50000, 24'd30000, 24'd19000, 24'd12000, 24'd8000,
      24'd5500, 24'd4000},
    '{24'd6700000, 24'd3400000, 24'd1750000, 24'd850000, 24'd420000, 24'd210000,
      24'd115000, 24'd64000, 24'd39000, 24'd24000, 24'd15500, 24'd10000, 24'd7000,
      24'd4800, 24'd3300},
    '{24'd5000000, 24'd2600000, 24'd1300000, 24'd630000, 24'd310000, 24'd160000,
      24'd87000, 24'd49000, 24'd31000, 24'd19500, 24'd13000, 24'd8400, 24'd5700,
      24'd4000, 24'd2800},
    '{24'd3900000, 24'd1900000, 24'd970000, 24'd460000, 24'd235000, 24'd125000,
      24'd69000, 24'd39000, 24'd25000, 24'd16000, 24'd10500, 24'd7200, 24'd5000,
      24'd3500, 24'd2500},
    '{24'd3000000, 24'd1500000, 24'd740000, 24'd380000, 24'd190000, 24'd100000,
      24'd56000, 24'd33000, 24'd20000, 24'd13000, 24'd9000, 24'd6200, 24'd4300,
      24'd3100, 24'd2200},
    '{24'd2400000, 24'd1100000, 24'd570000, 24'd280000, 24'd140000, 24'd78000,
      24'd45000, 24'd27000, 24'd17500, 24'd11500, 24'd8000, 24'd5600, 24'd3900,
      24'd2800, 24'd2000},
    '{24'd1750000, 24'd880000, 24'd420000, 24'd210000, 24'd110000, 24'd64000,
      24'd38000, 24'd24000, 24'd15000, 24'd10000, 24'd7000, 24'd4900, 24'd3400,
      24'd2400, 24'd1800},
    '{24'd1450000, 24'd700000, 24'd340000, 24'd170000, 24'd88000, 24'd50000,
      24'd31000, 24'd19500, 24'd13000, 24'd8600, 24'd6000, 24'd4200, 24'd3000,
      24'd2100, 24'd1550},
    '{24'd1150000, 24'd560000, 24'd270000, 24'd130000, 24'd70000, 24'd41000,
      24'd25000, 24'd17000, 24'd11000, 24'd7600, 24'd5400, 24'd3800, 24'd2700,
      24'd1900, 24'd1400},
    '{24'd970000, 24'd450000, 24'd215000, 24'd150000, 24'd57000, 24'd34000,
      24'd21000, 24'd14000, 24'd9400, 24'd6800, 24'd4800, 24'd3400, 24'd2500,
      24'd1800, 24'd1300}
  };

  localparam logic [COL_W-1:0] FIRST_COL [ROWS] = '{
    4'd2, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  // Humidity in percent at the given column of a row.
  function automatic logic [HUM_W-1:0] col_base(input logic [COL_W-1:0] col);
    logic [HUM_W-1:0] c;
    c = {{(HUM_W-COL_W){1'b0}}, col};
    return (c + HUM_W'(COL_OFS)) * HUM_W'(HUM_STEP);
  endfunction

endpackage
`default_nettype wire

// ===== design/hti_select.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Row and column select
// Picks the temperature row, searches its columns for the bracketing entry
// and forms the numerator, divisor and base humidity for the division.
// ----------------------------------------------------------------------------
module hti_select import hti_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [RES_W-1:0]         resistance,
  input  wire logic signed [TEMP_W-1:0] temperature,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [RES_W-1:0]              num,
  output logic [RES_W-1:0]              den,
  output logic                          mul10,
  output hti_ctl_t                      ctl
);

  logic               va;
  logic [ROW_W-1:0]   row;
  logic [RES_W-1:0]   res_a;
  logic               vb;
  logic               rdy_a;
  logic               rdy_b;

  logic [ROW_W-1:0]   row_next;
  logic [RES_W-1:0]   num_next;
  logic [RES_W-1:0]   den_next;
  logic               mul10_next;
  hti_ctl_t           ctl_next;

  assign rdy_b    = !vb || out_ready;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    row_next = ROW_W'(ROWS - 1);
    for (int c = ROWS - 1; c >= 0; c--) begin
      if (temperature <= $signed(TEMP_W'(TEMP_STEP * (2 * c + 1)))) begin
        row_next = ROW_W'(c);
      end
    end
  end

  always_comb begin
    res_t             tr [COLS];
    logic [COL_W-1:0] first;
    logic [COL_W-1:0] found;
    logic [COL_W-1:0] nxt;
    logic [COL_W-1:0] fnxt;
    logic             hit;
    tr    = RTAB[row];
    first = FIRST_COL[row];
    found = '0;
    hit   = 1'b0;
    for (int c = 0; c < COLS; c++) begin
      if (COL_W'(c) >= first && res_a <= tr[c]) begin
        found = COL_W'(c);
        hit   = 1'b1;
      end
    end
    nxt  = found + COL_W'(1);
    fnxt = first + COL_W'(1);
    if (hit && found == COL_W'(COLS - 1)) begin
      num_next      = tr[COLS-1] - res_a;
      den_next      = tr[COLS-2] - tr[COLS-1];
      mul10_next    = 1'b1;
      ctl_next.base = col_base(COL_W'(COLS - 1));
      ctl_next.sub  = 1'b0;
    end else if (hit) begin
      num_next      = tr[found] - res_a;
      den_next      = tr[found] - tr[nxt];
      mul10_next    = 1'b0;
      ctl_next.base = col_base(found);
      ctl_next.sub  = 1'b0;
    end else begin
      num_next      = res_a - tr[first];
      den_next      = tr[first] - tr[fnxt];
      mul10_next    = 1'b0;
      ctl_next.base = col_base(first);
      ctl_next.sub  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdy_a) begin
        va <= in_valid;
      end
      if (rdy_b) begin
        vb <= va;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      row   <= row_next;
      res_a <= resistance;
    end
    if (rdy_b) begin
      num   <= num_next;
      den   <= den_next;
      mul10 <= mul10_next;
      ctl   <= ctl_next;
    end
  end

  assign out_valid = vb;

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    va |-> row < ROW_W'(ROWS))
    else $error("Row index out of range.");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    vb |-> den != '0)
    else $error("Divisor of a valid item is zero.");

  a_inside_bracket: assert property (@(posedge clk) disable iff (rst)
    vb && !ctl.sub && !mul10 |-> num < den)
    else $error("Resistance is not bracketed by the chosen columns.");

endmodule
`default_nettype wire

// ===== design/hti_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled quotient pipeline
// Scales the numerator by five or ten and divides by the column step with a
// restoring division, one quotient bit per stage, saturating at all ones.
// ----------------------------------------------------------------------------
module hti_divider import hti_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [RES_W-1:0] num,
  input  wire logic [RES_W-1:0] den,
  input  wire logic             mul10,
  input  wire hti_ctl_t         ctl_in,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [QUO_W-1:0]      quotient,
  output hti_ctl_t              ctl_out
);

  localparam int NSTG = QUO_W + 2;
  localparam int CMP_W = RES_W + QUO_W;

  logic [NSTG-1:0]    v;
  logic [NSTG:0]      rdy;
  logic [SCALED_W-1:0] n_s   [NSTG];
  logic [RES_W-1:0]    d_s   [NSTG];
  logic [QUO_W-1:0]    q_s   [NSTG];
  logic                sat_s [NSTG];
  hti_ctl_t            c_s   [NSTG];

  logic [SCALED_W-1:0] n_next   [NSTG];
  logic [QUO_W-1:0]    q_next   [NSTG];
  logic                sat_next [NSTG];

  assign rdy[NSTG] = out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_comb begin
    logic [SCALED_W-1:0] x;
    logic [CMP_W-1:0]    trial;
    logic [CMP_W-1:0]    nx;
    x           = {{(SCALED_W-RES_W){1'b0}}, num};
    n_next[0]   = mul10 ? ((x << 3) + (x << 1)) : ((x << 2) + x);
    q_next[0]   = '0;
    sat_next[0] = 1'b0;

    n_next[1]   = n_s[0];
    q_next[1]   = q_s[0];
    sat_next[1] = sat_s[0];
    nx          = {{(CMP_W-SCALED_W){1'b0}}, n_s[0]};
    trial       = {d_s[0], {QUO_W{1'b0}}};
    if (nx >= trial) begin
      sat_next[1] = 1'b1;
      q_next[1]   = '1;
    end

    for (int k = 2; k < NSTG; k++) begin
      n_next[k]   = n_s[k-1];
      q_next[k]   = q_s[k-1];
      sat_next[k] = sat_s[k-1];
      nx          = {{(CMP_W-SCALED_W){1'b0}}, n_s[k-1]};
      trial       = {{QUO_W{1'b0}}, d_s[k-1]} << (NSTG - 1 - k);
      if (!sat_s[k-1] && nx >= trial) begin
        n_next[k] = SCALED_W'(nx - trial);
        q_next[k][NSTG - 1 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      n_s[0]   <= n_next[0];
      q_s[0]   <= q_next[0];
      sat_s[0] <= sat_next[0];
      d_s[0]   <= den;
      c_s[0]   <= ctl_in;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        n_s[k]   <= n_next[k];
        q_s[k]   <= q_next[k];
        sat_s[k] <= sat_next[k];
        d_s[k]   <= d_s[k-1];
        c_s[k]   <= c_s[k-1];
      end
    end
  end

  assign out_valid = v[NSTG-1];
  assign quotient  = q_s[NSTG-1];
  assign ctl_out   = c_s[NSTG-1];

  a_range_after_sat: assert property (@(posedge clk) disable iff (rst)
    v[1] && !sat_s[1] |->
      {{(CMP_W-SCALED_W){1'b0}}, n_s[1]} < {d_s[1], {QUO_W{1'b0}}})
    else $error("Unsaturated numerator exceeds the quotient range.");

  a_remainder: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sat_s[NSTG-1] |->
      n_s[NSTG-1] < {{(SCALED_W-RES_W){1'b0}}, d_s[NSTG-1]})
    else $error("Remainder is not below the divisor.");

  a_sat_quotient: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat_s[NSTG-1] |-> quotient == '1)
    else $error("Saturated item lost its all-ones quotient.");

endmodule
`default_nettype wire

// ===== design/humidity_table_interpolator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Humidity table interpolator
// Converts a sensor resistance and temperature into relative humidity by
// linear interpolation in a constant 13 by 15 resistance table.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled.
// Each item passes in order through the select stages, which pick the
// temperature row and then the bracketing table column, a stage that scales
// the numerator, the divider stages, which form the quotient in a restoring
// divider with a range check and then one bit per stage, and the output stage,
// which adds the base humidity and saturates the result to 10 .. 99 percent.
// Each stage holds its item while the next stage is full and stalled, so the
// input stalls only when every stage holds an item and the output is stalled.
module humidity_table_interpolator import hti_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     sample_valid,
  output logic                          sample_stall,
  input  wire logic [RES_W-1:0]         resistance_ohms,
  input  wire logic signed [TEMP_W-1:0] temperature_tenths,
  output logic                          humidity_valid,
  input  wire logic                     humidity_stall,
  output logic [HUM_W-1:0]              humidity_percent
);

  localparam int H_W = HUM_W + 2;

  logic               sel_ready;
  logic               sel_valid;
  logic               div_ready;
  logic               div_valid;
  logic               out_ready;
  logic [RES_W-1:0]   num;
  logic [RES_W-1:0]   den;
  logic               mul10;
  hti_ctl_t           sel_ctl;
  hti_ctl_t           div_ctl;
  logic [QUO_W-1:0]   quotient;
  logic [HUM_W-1:0]   humidity_next;

  hti_select u_select (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample_valid),
    .in_ready    (sel_ready),
    .resistance  (resistance_ohms),
    .temperature (temperature_tenths),
    .out_valid   (sel_valid),
    .out_ready   (div_ready),
    .num         (num),
    .den         (den),
    .mul10       (mul10),
    .ctl         (sel_ctl)
  );

  hti_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_ready  (div_ready),
    .num       (num),
    .den       (den),
    .mul10     (mul10),
    .ctl_in    (sel_ctl),
    .out_valid (div_valid),
    .out_ready (out_ready),
    .quotient  (quotient),
    .ctl_out   (div_ctl)
  );

  assign sample_stall = !sel_ready;
  assign out_ready    = !humidity_valid || !humidity_stall;

  always_comb begin
    logic signed [H_W-1:0] base;
    logic signed [H_W-1:0] q;
    logic signed [H_W-1:0] h;
    base = $signed({2'b00, div_ctl.base});
    q    = $signed({{(H_W-QUO_W){1'b0}}, quotient});
    h    = div_ctl.sub ? (base - q) : (base + q);
    if (h < $signed(H_W'(HUM_MIN))) begin
      humidity_next = HUM_W'(HUM_MIN);
    end else if (h > $signed(H_W'(HUM_MAX))) begin
      humidity_next = HUM_W'(HUM_MAX);
    end else begin
      humidity_next = h[HUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      humidity_valid <= 1'b0;
    end else if (out_ready) begin
      humidity_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      humidity_percent <= humidity_next;
    end
  end

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    humidity_valid |->
      humidity_percent >= HUM_W'(HUM_MIN) && humidity_percent <= HUM_W'(HUM_MAX))
    else $error("Humidity result outside 10 to 99 percent.");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> humidity_valid && humidity_stall && div_valid)
    else $error("Input stalled while the pipeline has room.");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    humidity_valid && humidity_stall |=> humidity_valid)
    else $error("A stalled item was dropped from the output register.");

endmodule
`default_nettype wire
